FILE: rtl/core/dcbhp_pkg.sv
// Shared types and constants for the DC-blocking high-pass filter core.
package dcbhp_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned DecayW  = 15;
  localparam int unsigned CountW  = 64;
  localparam int unsigned SumW    = SampleW + 2;
  localparam int unsigned ProdW   = 2 * SampleW;
  localparam int unsigned Q15Sh   = 15;

  localparam logic [DecayW-1:0]         DecayReset = 15'd32440;
  localparam logic signed [SampleW-1:0] SampleMax  = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SampleMin  = 16'sh8000;
  localparam logic signed [ProdW-1:0]   RoundBias  = 32'sd32767;

  typedef enum logic [0:0] {
    OP_FILTER = 1'b0,
    OP_CLEAR  = 1'b1
  } opcode_e;

endpackage

FILE: rtl/core/dc_block_high_pass_q15_core.sv
// DC-blocking high-pass filter core: y = x - x_prev + trunc(decay * y_prev / 32768), saturated.
//
// Takes one transaction per cycle unless the output stalls, so a steady stream sustains one
// sample per cycle. The figure is set by the feedback loop through the previous output: one
// 16x16 multiply, an add and saturation close combinationally. Accepted transactions wait in
// the input register; filter ones load the result register as they fire. Clear-history
// transactions zero the signal history, keep the clip count and produce no result. The decay
// register resets to 32440 and is meant to be written only while the core is idle.
module dc_block_high_pass_q15_core (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [dcbhp_pkg::DecayW-1:0]            cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    opcode_i,
  input  logic signed [dcbhp_pkg::SampleW-1:0]    sample_i,
  input  logic                                    block_end_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [dcbhp_pkg::SampleW-1:0]    filtered_o,
  output logic                                    clipped_o,
  output logic [dcbhp_pkg::CountW-1:0]            clip_total_o,
  output logic                                    block_last_o
);

  logic                                 in_valid_q;
  dcbhp_pkg::opcode_e                   opcode_q;
  logic signed [dcbhp_pkg::SampleW-1:0] sample_q;
  logic                                 block_end_q;

  logic [dcbhp_pkg::DecayW-1:0]         decay_q;
  logic signed [dcbhp_pkg::SampleW-1:0] last_in_q, last_in_d;
  logic signed [dcbhp_pkg::SampleW-1:0] last_out_q, last_out_d;
  logic [dcbhp_pkg::CountW-1:0]         clip_count_q, clip_count_d;

  logic                                 out_valid_q;
  logic signed [dcbhp_pkg::SampleW-1:0] filtered_q;
  logic                                 clipped_q;
  logic [dcbhp_pkg::CountW-1:0]         clip_total_q;
  logic                                 block_last_q;

  logic                                 out_free;
  logic                                 fire;
  logic                                 fire_filter;
  logic                                 in_take;

  logic signed [dcbhp_pkg::DecayW:0]    decay_s;
  logic signed [dcbhp_pkg::ProdW-1:0]   prod;
  logic signed [dcbhp_pkg::ProdW-1:0]   prod_adj;
  logic signed [dcbhp_pkg::SampleW-1:0] feedback;
  logic signed [dcbhp_pkg::SumW-1:0]    sum;
  logic                                 over;
  logic                                 under;
  logic                                 clip;
  logic signed [dcbhp_pkg::SampleW-1:0] y;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign fire        = in_valid_q && ((opcode_q == dcbhp_pkg::OP_CLEAR) || out_free);
  assign fire_filter = fire && (opcode_q == dcbhp_pkg::OP_FILTER);
  assign in_stall_o  = in_valid_q && !fire;
  assign in_take     = in_valid_i && !in_stall_o;

  // feedback term, truncated toward zero
  assign decay_s  = $signed({1'b0, decay_q});
  assign prod     = dcbhp_pkg::ProdW'(decay_s * last_out_q);
  assign prod_adj = prod + (prod[dcbhp_pkg::ProdW-1] ? dcbhp_pkg::RoundBias
                                                      : dcbhp_pkg::ProdW'(0));
  assign feedback = prod_adj[dcbhp_pkg::Q15Sh +: dcbhp_pkg::SampleW];

  assign sum = {{2{sample_q[dcbhp_pkg::SampleW-1]}}, sample_q}
             - {{2{last_in_q[dcbhp_pkg::SampleW-1]}}, last_in_q}
             + {{2{feedback[dcbhp_pkg::SampleW-1]}}, feedback};

  assign over  = !sum[dcbhp_pkg::SumW-1] && (sum[dcbhp_pkg::SumW-2:dcbhp_pkg::SampleW-1] != 2'b00);
  assign under = sum[dcbhp_pkg::SumW-1] && (sum[dcbhp_pkg::SumW-2:dcbhp_pkg::SampleW-1] != 2'b11);
  assign clip  = over || under;

  always_comb begin
    if (over) begin
      y = dcbhp_pkg::SampleMax;
    end else if (under) begin
      y = dcbhp_pkg::SampleMin;
    end else begin
      y = sum[dcbhp_pkg::SampleW-1:0];
    end
  end

  always_comb begin
    last_in_d    = last_in_q;
    last_out_d   = last_out_q;
    clip_count_d = clip_count_q;
    if (fire) begin
      if (opcode_q == dcbhp_pkg::OP_CLEAR) begin
        last_in_d  = '0;
        last_out_d = '0;
      end else begin
        last_in_d  = sample_q;
        last_out_d = y;
        if (clip && !(&clip_count_q)) begin
          clip_count_d = clip_count_q + dcbhp_pkg::CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      decay_q      <= dcbhp_pkg::DecayReset;
      last_in_q    <= '0;
      last_out_q   <= '0;
      clip_count_q <= '0;
    end else begin
      if (cfg_we_i) begin
        decay_q <= cfg_wdata_i;
      end
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire_filter) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      last_in_q    <= last_in_d;
      last_out_q   <= last_out_d;
      clip_count_q <= clip_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q    <= dcbhp_pkg::opcode_e'(opcode_i);
      sample_q    <= sample_i;
      block_end_q <= block_end_i;
    end
    if (fire_filter) begin
      filtered_q   <= y;
      clipped_q    <= clip;
      clip_total_q <= clip_count_d;
      block_last_q <= block_end_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign filtered_o   = filtered_q;
  assign clipped_o    = clipped_q;
  assign clip_total_o = clip_total_q;
  assign block_last_o = block_last_q;

`ifndef SYNTHESIS
  a_clip_rails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      (filtered_o == dcbhp_pkg::SampleMax) || (filtered_o == dcbhp_pkg::SampleMin))
    else $error("clipped result not at a rail");

  a_count_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> clip_count_q >= $past(clip_count_q))
    else $error("clip count decreased");

  a_stall_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && (opcode_q == dcbhp_pkg::OP_FILTER) && out_valid_q)
    else $error("input stalled without a blocked filter transaction");

  a_clear_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (opcode_q == dcbhp_pkg::OP_CLEAR) && out_stall_i |=> $stable(out_valid_o))
    else $error("clear transaction disturbed the result register");
`endif

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the DC-blocking high-pass filter core.
module tb;

  localparam int HalfPeriod = 5;
  localparam int DrainCycles = 8;
  localparam int HoldLen = 300;
  localparam int WatchdogLimit = 3000;
  localparam int Q15One = 1 << dcbhp_pkg::Q15Sh;

  typedef struct {
    logic signed [dcbhp_pkg::SampleW-1:0] filtered;
    logic                                 clipped;
    logic [dcbhp_pkg::CountW-1:0]         clip_total;
    logic                                 block_last;
  } hp_out_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [dcbhp_pkg::DecayW-1:0]         cfg_wdata_i = '0;
  logic                                 in_valid_i = 1'b0;
  logic                                 in_stall_o;
  logic                                 opcode_i = 1'b0;
  logic signed [dcbhp_pkg::SampleW-1:0] sample_i = '0;
  logic                                 block_end_i = 1'b0;
  logic                                 out_valid_o;
  logic                                 out_stall_i = 1'b0;
  logic signed [dcbhp_pkg::SampleW-1:0] filtered_o;
  logic                                 clipped_o;
  logic [dcbhp_pkg::CountW-1:0]         clip_total_o;
  logic                                 block_last_o;

  // filter state as the core should hold it
  logic [dcbhp_pkg::DecayW-1:0]         decay_cfg;
  logic signed [dcbhp_pkg::SampleW-1:0] hist_x;
  logic signed [dcbhp_pkg::SampleW-1:0] hist_y;
  logic [dcbhp_pkg::CountW-1:0]         clip_cnt;
  hp_out_t                              out_samples_q[$];
  hp_out_t                              want;

  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_go = 1'b0;
  int hold_cnt = 0;
  int idle_cnt = 0;
  int err_count = 0;
  int n_sent = 0;
  int n_clear = 0;
  int n_results = 0;
  int n_sat = 0;

  dc_block_high_pass_q15_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .sample_i     (sample_i),
    .block_end_i  (block_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .filtered_o   (filtered_o),
    .clipped_o    (clipped_o),
    .clip_total_o (clip_total_o),
    .block_last_o (block_last_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic void hp_filter_step(dcbhp_pkg::opcode_e op,
                                         logic signed [dcbhp_pkg::SampleW-1:0] x,
                                         logic be);
    int      fb;
    int      acc;
    hp_out_t r;
    if (op == dcbhp_pkg::OP_CLEAR) begin
      hist_x = '0;
      hist_y = '0;
      return;
    end
    fb  = (int'(decay_cfg) * int'(hist_y)) / Q15One;
    acc = int'(x) - int'(hist_x) + fb;
    r.clipped = 1'b0;
    if (acc > int'(dcbhp_pkg::SampleMax)) begin
      r.filtered = dcbhp_pkg::SampleMax;
      r.clipped  = 1'b1;
    end else if (acc < int'(dcbhp_pkg::SampleMin)) begin
      r.filtered = dcbhp_pkg::SampleMin;
      r.clipped  = 1'b1;
    end else begin
      r.filtered = acc[dcbhp_pkg::SampleW-1:0];
    end
    if (r.clipped && clip_cnt != '1) begin
      clip_cnt = clip_cnt + dcbhp_pkg::CountW'(1);
    end
    hist_x = x;
    hist_y = r.filtered;
    r.clip_total = clip_cnt;
    r.block_last = be;
    out_samples_q.push_back(r);
  endfunction

  // entered and left just after a falling edge
  task automatic send_item(dcbhp_pkg::opcode_e op, logic signed [dcbhp_pkg::SampleW-1:0] s,
                           logic be);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    opcode_i    = op;
    sample_i    = s;
    block_end_i = be;
    forever begin
      @(posedge clk_i);
      if (in_stall_o == 1'b0) break;
    end
    hp_filter_step(op, s, be);
    n_sent++;
    if (op == dcbhp_pkg::OP_CLEAR) n_clear++;
    @(negedge clk_i);
  endtask

  task automatic filt(logic signed [dcbhp_pkg::SampleW-1:0] s, logic be = 1'b0);
    send_item(dcbhp_pkg::OP_FILTER, s, be);
  endtask

  task automatic clear_hist();
    send_item(dcbhp_pkg::OP_CLEAR, 16'($urandom), 1'($urandom_range(1)));
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (out_samples_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_decay(logic [dcbhp_pkg::DecayW-1:0] v);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    decay_cfg = v;
  endtask

  function automatic logic signed [dcbhp_pkg::SampleW-1:0] clamp16(int v);
    if (v > int'(dcbhp_pkg::SampleMax)) return dcbhp_pkg::SampleMax;
    if (v < int'(dcbhp_pkg::SampleMin)) return dcbhp_pkg::SampleMin;
    return v[dcbhp_pkg::SampleW-1:0];
  endfunction

  // extremes, saturation both ways, negative truncation, clear history
  task automatic test_reset_decay();
    filt(16'sd0);
    filt(dcbhp_pkg::SampleMax);
    filt(dcbhp_pkg::SampleMin, 1'b1);
    filt(dcbhp_pkg::SampleMin);
    filt(dcbhp_pkg::SampleMin);
    filt(dcbhp_pkg::SampleMax, 1'b1);
    clear_hist();
    filt(dcbhp_pkg::SampleMax);
    clear_hist();
    clear_hist();
    filt(dcbhp_pkg::SampleMin, 1'b1);
    filt(-16'sd1);
    filt(16'sd1);
    filt(16'sd0, 1'b1);
  endtask

  task automatic test_decay_corners();
    // zero decay: plain differencer
    write_decay('0);
    filt(16'sd100);
    filt(16'sd100);
    filt(dcbhp_pkg::SampleMin);
    filt(dcbhp_pkg::SampleMax, 1'b1);
    write_decay('1);
    filt(dcbhp_pkg::SampleMax);
    filt(dcbhp_pkg::SampleMax);
    filt(dcbhp_pkg::SampleMax);
    filt(dcbhp_pkg::SampleMin, 1'b1);
    write_decay(15'd1);
    filt(dcbhp_pkg::SampleMin);
    filt(16'sd0);
    filt(16'sd5, 1'b1);
  endtask

  // blocks of DC plus noise, with odd items drawn from the full range and clears between
  task automatic test_random_phase(int ipct, int spct, logic [dcbhp_pkg::DecayW-1:0] d,
                                   int n);
    int start;
    int len;
    int dc;
    int amp;
    int noise;
    write_decay(d);
    idle_pct  = ipct;
    stall_pct = spct;
    start = n_sent;
    while (n_sent - start < n) begin
      case ($urandom_range(99)) inside
        [0:5]:  clear_hist();
        [6:13]: filt(16'($urandom), 1'($urandom_range(1)));
        default: begin
          len = $urandom_range(1, 12);
          dc  = $urandom_range(0, 65535) - 32768;
          amp = 1 << $urandom_range(0, 15);
          for (int i = 0; i < len; i++) begin
            noise = $urandom_range(0, 2 * amp) - amp;
            filt(clamp16(dc + noise), i == len - 1);
          end
        end
      endcase
    end
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // long receiver hold-off so the core fills, then a full pause before more traffic
  task automatic test_backpressure();
    write_decay(15'($urandom_range(1, 32767)));
    hold_go = 1'b1;
    for (int i = 0; i < 40; i++) filt(16'($urandom), 1'($urandom_range(1)));
    wait (hold_cnt >= HoldLen);
    hold_go = 1'b0;
    wait_drained();
    for (int i = 0; i < 20; i++) filt(16'($urandom), 1'($urandom_range(1)));
  endtask

  always @(negedge clk_i) begin
    if (!hold_go) hold_cnt = 0;
    if (hold_go && hold_cnt < HoldLen) begin
      hold_cnt++;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (out_samples_q.size() == 0) begin
        $error("unexpected result transaction, filtered %0d", filtered_o);
        err_count++;
      end else begin
        want = out_samples_q.pop_front();
        if (want.clipped) n_sat++;
        if (filtered_o !== want.filtered) begin
          $error("filtered: expected %0d, actual %0d", want.filtered, filtered_o);
          err_count++;
        end
        if (clipped_o !== want.clipped) begin
          $error("clipped: expected %0d, actual %0d", want.clipped, clipped_o);
          err_count++;
        end
        if (clip_total_o !== want.clip_total) begin
          $error("clip_total: expected %0d, actual %0d", want.clip_total, clip_total_o);
          err_count++;
        end
        if (block_last_o !== want.block_last) begin
          $error("block_last: expected %0d, actual %0d", want.block_last, block_last_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= WatchdogLimit) begin
        $display("watchdog: no transaction for %0d cycles", WatchdogLimit);
        $display("dc_block_high_pass_q15_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    decay_cfg = dcbhp_pkg::DecayReset;
    hist_x    = '0;
    hist_y    = '0;
    clip_cnt  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_decay();
    test_decay_corners();
    test_random_phase(0, 0, dcbhp_pkg::DecayReset, 120);
    test_random_phase(61, 0, 15'($urandom_range(1, 32767)), 120);
    test_random_phase(0, 61, '1, 120);
    test_random_phase(15, 15, 15'($urandom_range(1, 255)), 120);
    test_backpressure();
    wait_drained();
    if (out_samples_q.size() != 0) begin
      $error("%0d results never arrived", out_samples_q.size());
      err_count++;
    end
    $display("run: %0d items (%0d clear-history), %0d results, %0d saturated",
             n_sent, n_clear, n_results, n_sat);
    $display("decay corners 0/1/max, four idle/stall mixes, one long output hold-off");
    if (err_count == 0) begin
      $display("dc_block_high_pass_q15_core regression: pass");
    end else begin
      $display("dc_block_high_pass_q15_core regression: fail");
    end
    $finish;
  end

endmodule
